// ===== src/cxsw_pkg.sv =====
// shared types, codes and the chip x address map for the crosspoint write scheduler
package cxsw_pkg;

   localparam int X_FIELD_W = 4;
   localparam int Y_FIELD_W = 3;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_SET      = 2'd0;
   localparam opcode_type OP_OPEN_ALL = 2'd1;
   localparam opcode_type OP_TICK     = 2'd2;

   typedef logic [1:0] entry_type;
   localparam entry_type ENTRY_OPEN     = 2'd0;
   localparam entry_type ENTRY_CLOSED   = 2'd1;
   localparam entry_type ENTRY_TO_OPEN  = 2'd2;
   localparam entry_type ENTRY_TO_CLOSE = 2'd3;

   typedef struct packed {
      opcode_type             opcode;
      logic [X_FIELD_W-1:0]   x_index;
      logic [Y_FIELD_W-1:0]   y_index;
      logic                   turn_on;
   } req_type;

   typedef struct packed {
      logic                   write_valid;
      logic [X_FIELD_W-1:0]   chip_x_address;
      logic [Y_FIELD_W-1:0]   chip_y_address;
      logic                   chip_data;
      logic                   busy_res;
      entry_type              entry_state;
   } rsp_type;

   // lines 6..11 sit at codes 8..13, lines 12 and 13 at codes 6 and 7
   function automatic logic [X_FIELD_W-1:0] chip_x_code(input logic [X_FIELD_W-1:0] x);
      logic [X_FIELD_W-1:0] code;
      begin
         case (x)
            4'd6:    code = 4'd8;
            4'd7:    code = 4'd9;
            4'd8:    code = 4'd10;
            4'd9:    code = 4'd11;
            4'd10:   code = 4'd12;
            4'd11:   code = 4'd13;
            4'd12:   code = 4'd6;
            4'd13:   code = 4'd7;
            default: code = x;
         endcase
         return code;
      end
   endfunction

endpackage

// ===== src/cxsw_table.sv =====
// switch state memory: one write port, one read port with registered data
module cxsw_table
   import cxsw_pkg::*;
#(
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem_ff [2**ADDR_W];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/crosspoint_switch_write_scheduler_core.sv =====
// crosspoint write scheduler: switch table, scan on service tick, at most one chip write per tick
// open-all runs a fill sweep over the table; a service tick scans it with one table read per cycle
// throughput: one beat at a time; a new beat is taken the cycle the result strobe shows
// reset: synchronous, active high; a clearing pass then writes every table entry open
// with busy high; the enable register is written as ever
module crosspoint_switch_write_scheduler_core
   import cxsw_pkg::*;
#(
   parameter int X_LINES = 16,
   parameter int Y_LINES = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int XW = (X_LINES > 1) ? $clog2(X_LINES) : 1;
   localparam int YW = (Y_LINES > 1) ? $clog2(Y_LINES) : 1;
   localparam int AW = XW + YW;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_FILL  = 6'b000100,
      S_SCAN  = 6'b001000,
      S_READ  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   rsp_type   res_ff, res_in;
   logic      strobe_ff, strobe_in;
   logic      enable_ff, enable_in;
   logic      pending_ff, pending_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [XW-1:0] sx_ff, sx_in, chk_x_ff, chk_x_in;
   logic [YW-1:0] sy_ff, sy_in, chk_y_ff, chk_y_in;
   logic      issue_done_ff, issue_done_in;
   logic      chk_v_ff, chk_v_in;
   logic      chk_last_ff, chk_last_in;
   logic      found_ff, found_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic          accept;
   logic          req_in_range, item_in_range;
   logic [AW-1:0] req_addr, item_addr;
   logic          scan_last;

   cxsw_table #(.ADDR_W(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign req_in_range  = (32'(req_item.x_index) < X_LINES) && (32'(req_item.y_index) < Y_LINES);
   assign item_in_range = (32'(item_ff.x_index) < X_LINES) && (32'(item_ff.y_index) < Y_LINES);
   assign req_addr      = {req_item.x_index[XW-1:0], req_item.y_index[YW-1:0]};
   assign item_addr     = {item_ff.x_index[XW-1:0], item_ff.y_index[YW-1:0]};
   assign scan_last     = (sx_ff == XW'(X_LINES - 1)) && (sy_ff == YW'(Y_LINES - 1));

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      res_in        = res_ff;
      strobe_in     = 1'b0;
      enable_in     = csr_wr_en ? csr_wr_data : enable_ff;
      pending_in    = pending_ff;
      sweep_in      = sweep_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      issue_done_in = issue_done_ff;
      chk_v_in      = 1'b0;
      chk_x_in      = sx_ff;
      chk_y_in      = sy_ff;
      chk_last_in   = scan_last;
      found_in      = found_ff;
      wr_en         = 1'b0;
      wr_addr       = sweep_ff;
      wr_data       = ENTRY_OPEN;
      rd_addr       = item_addr;

      case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (&sweep_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               item_in = req_item;
               res_in  = '0;
               case (req_item.opcode)
                  OP_SET: begin
                     wr_en   = req_in_range;
                     wr_addr = req_addr;
                     wr_data = req_item.turn_on ? ENTRY_TO_CLOSE : ENTRY_TO_OPEN;
                     if (enable_ff) begin
                        pending_in = 1'b1;
                     end
                     state_in = S_READ;
                  end
                  OP_OPEN_ALL: begin
                     if (enable_ff) begin
                        pending_in = 1'b1;
                     end
                     sweep_in = '0;
                     state_in = S_FILL;
                  end
                  OP_TICK: begin
                     if (enable_ff && pending_ff) begin
                        sx_in         = '0;
                        sy_in         = '0;
                        issue_done_in = 1'b0;
                        found_in      = 1'b0;
                        state_in      = S_SCAN;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_FILL: begin
            wr_en    = 1'b1;
            wr_data  = ENTRY_TO_OPEN;
            sweep_in = sweep_ff + AW'(1);
            if (&sweep_ff) begin
               state_in = S_READ;
            end
         end
         S_SCAN: begin
            // read one entry per cycle, check the entry read the cycle before
            rd_addr = {sx_ff, sy_ff};
            if (!issue_done_ff) begin
               chk_v_in = 1'b1;
               if (sy_ff == YW'(Y_LINES - 1)) begin
                  sy_in = '0;
                  if (sx_ff == XW'(X_LINES - 1)) begin
                     issue_done_in = 1'b1;
                  end else begin
                     sx_in = sx_ff + XW'(1);
                  end
               end else begin
                  sy_in = sy_ff + YW'(1);
               end
            end
            if (chk_v_ff && rd_data[1]) begin
               if (!found_ff) begin
                  // first pending entry: write it to the chip and settle it
                  found_in              = 1'b1;
                  wr_en                 = 1'b1;
                  wr_addr               = {chk_x_ff, chk_y_ff};
                  wr_data               = {1'b0, rd_data[0]};
                  res_in.write_valid    = 1'b1;
                  res_in.chip_x_address = chip_x_code(X_FIELD_W'(chk_x_ff));
                  res_in.chip_y_address = Y_FIELD_W'(chk_y_ff);
                  res_in.chip_data      = rd_data[0];
                  if (chk_last_ff) begin
                     pending_in = 1'b0;
                     state_in   = S_READ;
                  end
               end else begin
                  // another entry still waits, so the flag stays up
                  state_in = S_READ;
               end
            end else if (chk_v_ff && chk_last_ff) begin
               pending_in = 1'b0;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            res_in.busy_res    = pending_ff;
            res_in.entry_state = item_in_range ? rd_data : ENTRY_OPEN;
            strobe_in          = 1'b1;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         strobe_ff  <= 1'b0;
         enable_ff  <= 1'b0;
         pending_ff <= 1'b0;
         sweep_ff   <= '0;
         chk_v_ff   <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         enable_ff  <= enable_in;
         pending_ff <= pending_in;
         sweep_ff   <= sweep_in;
         chk_v_ff   <= chk_v_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      res_ff        <= res_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      issue_done_ff <= issue_done_in;
      chk_x_ff      <= chk_x_in;
      chk_y_ff      <= chk_y_in;
      chk_last_ff   <= chk_last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = res_ff;

   // a result beat only shows once the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("one beat gave two result strobes");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.write_valid) |->
         (rsp_item.chip_x_address == '0 && rsp_item.chip_y_address == '0 &&
          !rsp_item.chip_data))
      else $error("write fields set without a chip write");

endmodule

// ===== dv/crosspoint_write_monitor.sv =====
// crosspoint write monitor: tracks the switch table, predicts each response beat and compares it
module crosspoint_write_monitor
   import cxsw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   output int      mismatch_count,
   output int      writes_owed
);

   localparam int X_LINES = 16;
   localparam int Y_LINES = 8;

   entry_type switch_state [X_LINES][Y_LINES];
   logic      pending_flag;
   logic      enabled;
   rsp_type   expected_writes [$];
   int        fails = 0;

   // x lines 6..11 move up by two, 12 and 13 drop to 6 and 7
   function automatic logic [X_FIELD_W-1:0] x_line_code(input logic [X_FIELD_W-1:0] line);
      logic [X_FIELD_W-1:0] code;
      if (line >= 4'd6 && line <= 4'd11) begin
         code = line + 4'd2;
      end else if (line == 4'd12 || line == 4'd13) begin
         code = line - 4'd6;
      end else begin
         code = line;
      end
      return code;
   endfunction

   task automatic schedule_write(input req_type beat, output rsp_type predicted);
      logic found;
      logic left;
      found     = 1'b0;
      left      = 1'b0;
      predicted = '0;
      case (beat.opcode)
         OP_SET: begin
            switch_state[beat.x_index][beat.y_index] =
               beat.turn_on ? ENTRY_TO_CLOSE : ENTRY_TO_OPEN;
            if (enabled) pending_flag = 1'b1;
         end
         OP_OPEN_ALL: begin
            for (int x = 0; x < X_LINES; x++) begin
               for (int y = 0; y < Y_LINES; y++) switch_state[x][y] = ENTRY_TO_OPEN;
            end
            if (enabled) pending_flag = 1'b1;
         end
         OP_TICK: begin
            if (enabled && pending_flag) begin
               // first pending entry, x outer and y inner
               for (int x = 0; x < X_LINES; x++) begin
                  for (int y = 0; y < Y_LINES; y++) begin
                     if (!found && switch_state[x][y] >= ENTRY_TO_OPEN) begin
                        found                    = 1'b1;
                        predicted.write_valid    = 1'b1;
                        predicted.chip_x_address = x_line_code(x[X_FIELD_W-1:0]);
                        predicted.chip_y_address = y[Y_FIELD_W-1:0];
                        predicted.chip_data      = (switch_state[x][y] == ENTRY_TO_CLOSE);
                        switch_state[x][y] = (switch_state[x][y] == ENTRY_TO_CLOSE) ?
                                             ENTRY_CLOSED : ENTRY_OPEN;
                     end
                  end
               end
               for (int x = 0; x < X_LINES; x++) begin
                  for (int y = 0; y < Y_LINES; y++) begin
                     if (switch_state[x][y] >= ENTRY_TO_OPEN) left = 1'b1;
                  end
               end
               if (!left) pending_flag = 1'b0;
            end
         end
         default: begin
         end
      endcase
      predicted.busy_res    = pending_flag;
      predicted.entry_state = switch_state[beat.x_index][beat.y_index];
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int x = 0; x < X_LINES; x++) begin
            for (int y = 0; y < Y_LINES; y++) switch_state[x][y] = ENTRY_OPEN;
         end
         pending_flag = 1'b0;
         enabled      = 1'b0;
         expected_writes.delete();
      end else begin
         if (csr_wr_en) enabled = csr_wr_data;
         // the response beat of the older item is retired before the new beat is predicted
         if (rsp_strobe) begin
            if (expected_writes.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected response beat: wv=%0d x=%0d y=%0d d=%0d busy=%0d st=%0d",
                           rsp_item.write_valid, rsp_item.chip_x_address,
                           rsp_item.chip_y_address, rsp_item.chip_data,
                           rsp_item.busy_res, rsp_item.entry_state);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_item.write_valid    !== want.write_valid    ||
                   rsp_item.chip_x_address !== want.chip_x_address ||
                   rsp_item.chip_y_address !== want.chip_y_address ||
                   rsp_item.chip_data      !== want.chip_data      ||
                   rsp_item.busy_res       !== want.busy_res       ||
                   rsp_item.entry_state    !== want.entry_state) begin
                  fails++;
                  if (fails <= 10)
                     $display("mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                              want.write_valid, want.chip_x_address, want.chip_y_address,
                              want.chip_data, want.busy_res, want.entry_state,
                              rsp_item.write_valid, rsp_item.chip_x_address,
                              rsp_item.chip_y_address, rsp_item.chip_data,
                              rsp_item.busy_res, rsp_item.entry_state);
               end
            end
         end
         if (start && !busy) begin
            schedule_write(req_item, want);
            expected_writes.push_back(want);
         end
      end
      mismatch_count <= fails;
      writes_owed    <= expected_writes.size();
   end

endmodule

// ===== dv/crosspoint_switch_write_scheduler_core_test.sv =====
// testbench top for the crosspoint write scheduler: stimulus, enable phases and verdict
module crosspoint_switch_write_scheduler_core_test
   import cxsw_pkg::*;
();

   localparam opcode_type OP_UNUSED = 2'd3;
   localparam int BEATS_PER_PHASE = 140;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_item    = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;
   int      mismatch_count;
   int      writes_owed;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   crosspoint_switch_write_scheduler_core #(
      .X_LINES(16),
      .Y_LINES(8)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   crosspoint_write_monitor monitor (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .writes_owed   (writes_owed)
   );

   task automatic send_beat(input opcode_type op, input logic [X_FIELD_W-1:0] x,
                            input logic [Y_FIELD_W-1:0] y, input logic on, input bit idle_ok);
      if (idle_ok && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 18)) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= '{op, x, y, on};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold off until every response beat owed has come back
   task automatic wait_all_written();
      @(negedge clock);
      start <= 1'b0;
      while (writes_owed != 0) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      wait_all_written();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_beat(input bit idle_ok);
      int         pick;
      opcode_type op;
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = OP_SET;
      else if (pick < 40) op = OP_OPEN_ALL;
      else if (pick < 44) op = OP_UNUSED;
      else                op = OP_TICK;
      send_beat(op, X_FIELD_W'($urandom_range(0, 15)), Y_FIELD_W'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), idle_ok);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // disabled: table is marked but nothing gets scheduled
      send_beat(OP_SET,      4'd15, 3'd7, 1'b1, 1'b0);
      send_beat(OP_TICK,     4'd15, 3'd7, 1'b0, 1'b0);
      send_beat(OP_UNUSED,   4'd0,  3'd0, 1'b1, 1'b0);
      send_beat(OP_OPEN_ALL, 4'd3,  3'd2, 1'b0, 1'b0);
      send_beat(OP_TICK,     4'd0,  3'd0, 1'b0, 1'b0);

      write_enable(1'b1);
      send_beat(OP_SET,  4'd0,  3'd0, 1'b1, 1'b0);
      send_beat(OP_SET,  4'd15, 3'd7, 1'b1, 1'b0);
      send_beat(OP_SET,  4'd6,  3'd1, 1'b0, 1'b0);
      send_beat(OP_TICK, 4'd0,  3'd0, 1'b0, 1'b0);
      send_beat(OP_TICK, 4'd0,  3'd1, 1'b1, 1'b0);
      send_beat(OP_UNUSED, 4'd15, 3'd7, 1'b0, 1'b0);

      // disable while a write is pending, then serve it after re-enable
      write_enable(1'b0);
      send_beat(OP_TICK, 4'd0,  3'd1, 1'b0, 1'b0);
      send_beat(OP_SET,  4'd12, 3'd4, 1'b1, 1'b0);
      write_enable(1'b1);
      send_beat(OP_TICK, 4'd12, 3'd4, 1'b0, 1'b0);
      send_beat(OP_TICK, 4'd13, 3'd5, 1'b1, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         write_enable(phase == 2 ? 1'b0 : 1'b1);
         for (int n = 0; n < BEATS_PER_PHASE; n++) random_beat(phase != 3);
      end

      wait_all_written();
      repeat (140) @(posedge clock);
      if (mismatch_count == 0 && writes_owed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/cxsw_pkg.sv
src/cxsw_table.sv
src/crosspoint_switch_write_scheduler_core.sv
dv/crosspoint_write_monitor.sv
dv/crosspoint_switch_write_scheduler_core_test.sv
